// ----- sv/bfcr_pkg.sv -----
// Package for the bit field copy realigner.
// Holds the register index codes and the result record types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfcr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AccW  = 15;
  localparam logic [ByteW-1:0] ByteAll = 8'hFF;

  typedef enum logic [1:0] {
    REG_SRC_BIT_OFFSET  = 2'd0,
    REG_DEST_BIT_OFFSET = 2'd1,
    REG_BIT_COUNT       = 2'd2,
    REG_NONE            = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] dest_byte;
    logic [ByteW-1:0] write_mask;
    logic             last_out;
  } result_t;

  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } pair_t;

endpackage

`default_nettype wire

// ----- sv/bit_field_copy_realigner.sv -----
// Top level of the bit field copy realigner.
// Depends on bfcr_pkg for register codes and result record types.
//
// Usage: source bytes enter on the in channel (in_valid_i, in_ready_o,
// src_byte_i), one byte per request, starting with the byte that holds the
// first bit of the field. Destination bytes leave on the out channel
// (out_valid_o, out_ready_i) with a per-bit write mask and a last marker.
// The offsets and the bit count are set over the APB port while idle; a
// transfer starts with the first byte after the previous one ended.
// A result is registered into the queue when its source byte is accepted.
// One source byte is accepted every cycle while in_ready_o is high; each gives at
// most one result except the final byte, which may give two, and the two
// leave on the out channel one after the other. Results wait in a
// two-entry queue of result pairs, so input keeps flowing while one result
// waits; in_ready_o drops only when both entries are occupied.
// A zero bit count makes a source byte give no result.
// Reset clears the registers, the transfer state and the queue.
`timescale 1ns / 1ps
`default_nettype none

module bit_field_copy_realigner #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  src_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       dest_byte_o,
  output logic [7:0]       write_mask_o,
  output logic             last_out_o
);

  logic [2:0]             src_off_q;
  logic [2:0]             dest_off_q;
  logic [COUNT_WIDTH-1:0] bit_count_q;

  logic [bfcr_pkg::AccW-1:0] acc_q, acc_d;
  logic [3:0]                held_q, held_d;
  logic [COUNT_WIDTH-1:0]    rem_q, rem_d;
  logic                      first_q, first_d;

  bfcr_pkg::pair_t fifo_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            sub_q;

  logic cfg_wr;
  bfcr_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = bfcr_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      bfcr_pkg::REG_SRC_BIT_OFFSET:  prdata = 32'(src_off_q);
      bfcr_pkg::REG_DEST_BIT_OFFSET: prdata = 32'(dest_off_q);
      bfcr_pkg::REG_BIT_COUNT:       prdata = 32'(bit_count_q);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_off_q   <= '0;
      dest_off_q  <= '0;
      bit_count_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bfcr_pkg::REG_SRC_BIT_OFFSET:  src_off_q   <= pwdata[2:0];
        bfcr_pkg::REG_DEST_BIT_OFFSET: dest_off_q  <= pwdata[2:0];
        bfcr_pkg::REG_BIT_COUNT:       bit_count_q <= pwdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Realignment of one source byte.
  logic                      start;
  logic                      empty_start;
  logic [COUNT_WIDTH-1:0]    rem_eff;
  logic [3:0]                held_eff;
  logic [bfcr_pkg::AccW-1:0] acc_eff;
  logic                      first_eff;
  logic [2:0]                skip;
  logic [3:0]                take_full;
  logic [3:0]                take;
  logic [7:0]                take_mask;
  logic [7:0]                bits;
  logic [bfcr_pkg::AccW-1:0] acc1;
  logic [3:0]                held1;
  logic [COUNT_WIDTH-1:0]    rem1;
  logic                      emit0;
  logic [7:0]                head0;
  logic [bfcr_pkg::AccW-1:0] acc2;
  logic [3:0]                held2;
  logic                      first2;
  logic                      done;
  logic                      tail;
  logic [7:0]                head1;
  logic [7:0]                tail_mask;
  bfcr_pkg::result_t         res_emit;
  bfcr_pkg::result_t         res_tail;
  bfcr_pkg::pair_t           pair_new;
  logic                      push;
  logic                      in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    start       = (rem_q == '0);
    empty_start = start && (bit_count_q == '0);
    rem_eff     = start ? bit_count_q : rem_q;
    held_eff    = start ? {1'b0, dest_off_q} : held_q;
    acc_eff     = start ? '0 : acc_q;
    first_eff   = start ? 1'b1 : first_q;
    skip        = start ? src_off_q : 3'd0;

    take_full = 4'd8 - {1'b0, skip};
    take      = (rem_eff < COUNT_WIDTH'(take_full)) ? rem_eff[3:0] : take_full;
    take_mask = 8'((9'd1 << take) - 9'd1);
    bits      = (src_byte_i >> skip) & take_mask;
    acc1      = acc_eff | (bfcr_pkg::AccW'(bits) << held_eff);
    held1     = held_eff + take;
    rem1      = rem_eff - COUNT_WIDTH'(take);

    emit0 = (held1 >= 4'd8);
    head0 = first_eff ? 8'(bfcr_pkg::ByteAll << dest_off_q) : bfcr_pkg::ByteAll;
    if (emit0) begin
      acc2   = acc1 >> 8;
      held2  = held1 - 4'd8;
      first2 = 1'b0;
    end else begin
      acc2   = acc1;
      held2  = held1;
      first2 = first_eff;
    end

    done      = (rem1 == '0);
    tail      = done && (held2 != 4'd0);
    head1     = first2 ? 8'(bfcr_pkg::ByteAll << dest_off_q) : bfcr_pkg::ByteAll;
    tail_mask = head1 & 8'(bfcr_pkg::ByteAll >> (4'd8 - held2));

    res_emit.write_mask = head0;
    res_emit.dest_byte  = acc1[7:0] & head0;
    res_emit.last_out   = done && !tail;
    res_tail.write_mask = tail_mask;
    res_tail.dest_byte  = acc2[7:0] & tail_mask;
    res_tail.last_out   = 1'b1;

    pair_new.r0  = emit0 ? res_emit : res_tail;
    pair_new.r1  = res_tail;
    pair_new.two = emit0 && tail;

    push = in_acc && !empty_start && (emit0 || tail);

    acc_d   = acc_q;
    held_d  = held_q;
    rem_d   = rem_q;
    first_d = first_q;
    if (in_acc && !empty_start) begin
      rem_d = rem1;
      if (done) begin
        acc_d   = '0;
        held_d  = 4'd0;
        first_d = 1'b1;
      end else begin
        acc_d   = acc2;
        held_d  = held2;
        first_d = first2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      held_q  <= '0;
      rem_q   <= '0;
      first_q <= 1'b1;
    end else begin
      acc_q   <= acc_d;
      held_q  <= held_d;
      rem_q   <= rem_d;
      first_q <= first_d;
    end
  end

  // Result queue: two entries, each holding the results of one source byte.
  bfcr_pkg::pair_t   cur;
  bfcr_pkg::result_t cur_res;
  logic              pop;
  logic              pop_entry;

  assign cur         = fifo_q[rd_ptr_q];
  assign cur_res     = sub_q ? cur.r1 : cur.r0;
  assign out_valid_o = (cnt_q != 2'd0);
  assign dest_byte_o  = cur_res.dest_byte;
  assign write_mask_o = cur_res.write_mask;
  assign last_out_o   = cur_res.last_out;
  assign in_ready_o  = (cnt_q != 2'd2);
  assign pop         = out_valid_o && out_ready_i;
  assign pop_entry   = pop && (sub_q || !cur.two);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= pair_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      sub_q    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_entry) begin
        rd_ptr_q <= !rd_ptr_q;
        sub_q    <= 1'b0;
      end else if (pop) begin
        sub_q    <= 1'b1;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_entry);
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q[3])
    else $error("more than seven bits held between source bytes");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q == '0) |-> (held_q == 4'd0 && acc_q == '0 && first_q))
    else $error("transfer state not cleared while idle");

  a_sub_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (cnt_q != 2'd0 && cur.two))
    else $error("second result selected from a single-result entry");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_bit_field_copy_realigner.sv -----
// Testbench for bit_field_copy_realigner: a directed table, then random transfers under
// four idle and stall phases; results checked against table rows or a realignment predictor.
// Depends on bfcr_pkg and the bit_field_copy_realigner RTL.
`timescale 1ns / 1ps

module tb_bit_field_copy_realigner;

  localparam int unsigned CountW     = 24;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned NumRows    = 22;
  localparam int unsigned RandItems  = 1700;
  localparam int unsigned NumPhases  = 4;

  typedef struct packed {
    logic [31:0]       src_word;
    logic [31:0]       dst_word;
    logic [31:0]       count_word;
    logic [7:0]        src_byte;
    logic              typed;
    logic [1:0]        n_res;
    bfcr_pkg::result_t res0;
    bfcr_pkg::result_t res1;
  } stim_row_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  src_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  dest_byte;
  logic [7:0]  write_mask;
  logic        last_out;

  logic [2:0]                cfg_src_off   = '0;
  logic [2:0]                cfg_dst_off   = '0;
  logic [CountW-1:0]         cfg_count     = '0;
  logic [bfcr_pkg::AccW-1:0] acc_bits      = '0;
  logic [3:0]                acc_held      = '0;
  logic [CountW-1:0]         bits_left     = '0;
  logic                      first_pending = 1'b1;

  bfcr_pkg::result_t dest_bytes_due[$];
  logic              typed_on = 1'b0;
  int                typed_n  = 0;
  bfcr_pkg::result_t typed_r0 = '0;
  bfcr_pkg::result_t typed_r1 = '0;

  int errors         = 0;
  int cycles         = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  int src_idle_tab[NumPhases]   = '{0, 61, 0, 37};
  int sink_stall_tab[NumPhases] = '{0, 0, 61, 37};

  bit_field_copy_realigner #(.COUNT_WIDTH(CountW)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .src_byte_i  (src_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .dest_byte_o (dest_byte),
    .write_mask_o(write_mask),
    .last_out_o  (last_out)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] head_mask();
    return first_pending ? 8'(bfcr_pkg::ByteAll << cfg_dst_off) : bfcr_pkg::ByteAll;
  endfunction

  task automatic realign_src_byte(input logic [7:0] value);
    int                skip;
    int                take;
    int                n;
    logic [7:0]        bits;
    logic [7:0]        mask;
    bfcr_pkg::result_t res [2];
    skip = 0;
    n = 0;
    if (bits_left == '0) begin
      if (cfg_count == '0) return;
      bits_left = cfg_count;
      acc_bits = '0;
      acc_held = 4'(cfg_dst_off);
      first_pending = 1'b1;
      skip = int'(cfg_src_off);
    end
    take = 8 - skip;
    if (bits_left < CountW'(take)) take = int'(bits_left);
    bits = 8'((int'(value) >> skip) & ((1 << take) - 1));
    acc_bits = bfcr_pkg::AccW'(int'(acc_bits) | (int'(bits) << acc_held));
    acc_held = acc_held + 4'(take);
    bits_left = bits_left - CountW'(take);
    if (acc_held >= 4'd8) begin
      mask = head_mask();
      res[n] = '{dest_byte: acc_bits[7:0] & mask, write_mask: mask, last_out: 1'b0};
      n++;
      acc_bits = acc_bits >> 8;
      acc_held = acc_held - 4'd8;
      first_pending = 1'b0;
    end
    if (bits_left == '0) begin
      if (acc_held != 4'd0) begin
        mask = head_mask() & 8'(bfcr_pkg::ByteAll >> (8 - acc_held));
        res[n] = '{dest_byte: acc_bits[7:0] & mask, write_mask: mask, last_out: 1'b0};
        n++;
      end
      if (n > 0) res[n-1].last_out = 1'b1;
      acc_bits = '0;
      acc_held = '0;
      first_pending = 1'b1;
    end
    for (int i = 0; i < n; i++) dest_bytes_due.push_back(res[i]);
  endtask

  task automatic apply_reg_write(input bfcr_pkg::reg_idx_e idx, input logic [31:0] value);
    case (idx)
      bfcr_pkg::REG_SRC_BIT_OFFSET:  cfg_src_off = value[2:0];
      bfcr_pkg::REG_DEST_BIT_OFFSET: cfg_dst_off = value[2:0];
      bfcr_pkg::REG_BIT_COUNT:       cfg_count = value[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic apb_write(input bfcr_pkg::reg_idx_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    apply_reg_write(idx, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_read_check(input bfcr_pkg::reg_idx_e idx, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      errors++;
      $display("%0t: register %s read expected %h actual %h", $time, idx.name(), want, prdata);
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_src_byte(input logic [7:0] value);
    while (int'($urandom_range(99)) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    src_byte <= value;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // A zero-count request leaves no trace in the queue, so the drain waits on after
  // the queue empties to let any work still inside the block settle before the registers move.
  task automatic drain_dest_bytes();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (dest_bytes_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_config(input logic [31:0] s_word, input logic [31:0] d_word,
                              input logic [31:0] c_word);
    drain_dest_bytes();
    apb_write(bfcr_pkg::REG_SRC_BIT_OFFSET, s_word);
    apb_write(bfcr_pkg::REG_DEST_BIT_OFFSET, d_word);
    apb_write(bfcr_pkg::REG_BIT_COUNT, c_word);
    apb_read_check(bfcr_pkg::REG_SRC_BIT_OFFSET, {29'b0, cfg_src_off});
    apb_read_check(bfcr_pkg::REG_DEST_BIT_OFFSET, {29'b0, cfg_dst_off});
    apb_read_check(bfcr_pkg::REG_BIT_COUNT, {8'b0, cfg_count});
  endtask

  always @(negedge clk_i) begin
    out_ready <= (int'($urandom_range(99)) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb_bit_field_copy_realigner: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin : scoreboard
    int                depth;
    bfcr_pkg::result_t got;
    bfcr_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        got = '{dest_byte: dest_byte, write_mask: write_mask, last_out: last_out};
        if (dest_bytes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result dest_byte=%h write_mask=%h last_out=%b",
                   $time, got.dest_byte, got.write_mask, got.last_out);
        end else begin
          want = dest_bytes_due.pop_front();
          if (got.dest_byte !== want.dest_byte) begin
            errors++;
            $display("%0t: dest_byte expected %h actual %h", $time, want.dest_byte,
                     got.dest_byte);
          end
          if (got.write_mask !== want.write_mask) begin
            errors++;
            $display("%0t: write_mask expected %h actual %h", $time, want.write_mask,
                     got.write_mask);
          end
          if (got.last_out !== want.last_out) begin
            errors++;
            $display("%0t: last_out expected %b actual %b", $time, want.last_out,
                     got.last_out);
          end
        end
      end
      if (in_valid && in_ready) begin
        depth = dest_bytes_due.size();
        realign_src_byte(src_byte);
        if (typed_on) begin
          while (dest_bytes_due.size() > depth) void'(dest_bytes_due.pop_back());
          if (typed_n > 0) dest_bytes_due.push_back(typed_r0);
          if (typed_n > 1) dest_bytes_due.push_back(typed_r1);
        end
      end
    end
  end

  initial begin : main_seq
    stim_row_t         rows [NumRows];
    int                sent;
    int                nbytes;
    int                pick;
    bit                fresh;
    logic [2:0]        s_off;
    logic [2:0]        d_off;
    logic [CountW-1:0] cnt;

    rows = '{
      '{32'd0, 32'd0, 32'd0, 8'hFF, 1'b1, 2'd0, '0, '0},
      '{32'd0, 32'd0, 32'd8, 8'hA5, 1'b1, 2'd1, '{8'hA5, 8'hFF, 1'b1}, '0},
      '{32'd0, 32'd0, 32'd8, 8'h00, 1'b1, 2'd1, '{8'h00, 8'hFF, 1'b1}, '0},
      '{32'd0, 32'd0, 32'd8, 8'hFF, 1'b1, 2'd1, '{8'hFF, 8'hFF, 1'b1}, '0},
      '{32'd7, 32'd7, 32'd1, 8'h80, 1'b1, 2'd1, '{8'h80, 8'h80, 1'b1}, '0},
      '{32'd7, 32'd7, 32'd1, 8'h7F, 1'b1, 2'd1, '{8'h00, 8'h80, 1'b1}, '0},
      '{32'd0, 32'd0, 32'd1, 8'h01, 1'b1, 2'd1, '{8'h01, 8'h01, 1'b1}, '0},
      '{32'd0, 32'd4, 32'd8, 8'hA5, 1'b1, 2'd2, '{8'h50, 8'hF0, 1'b0},
        '{8'h0A, 8'h0F, 1'b1}},
      '{32'd0, 32'd7, 32'd8, 8'hFF, 1'b1, 2'd2, '{8'h80, 8'h80, 1'b0},
        '{8'h7F, 8'h7F, 1'b1}},
      '{32'hFFFF_FFF8, 32'hFFFF_FFF8, 32'hFF00_0008, 8'h3C, 1'b1, 2'd1,
        '{8'h3C, 8'hFF, 1'b1}, '0},
      '{32'd3, 32'd0, 32'd5, 8'hF8, 1'b1, 2'd1, '{8'h1F, 8'h1F, 1'b1}, '0},
      '{32'd7, 32'd0, 32'd16, 8'h80, 1'b0, 2'd0, '0, '0},
      '{32'd7, 32'd0, 32'd16, 8'h5A, 1'b0, 2'd0, '0, '0},
      '{32'd7, 32'd0, 32'd16, 8'hC3, 1'b0, 2'd0, '0, '0},
      '{32'd5, 32'd3, 32'd20, 8'h12, 1'b0, 2'd0, '0, '0},
      '{32'd5, 32'd3, 32'd20, 8'h34, 1'b0, 2'd0, '0, '0},
      '{32'd5, 32'd3, 32'd20, 8'h56, 1'b0, 2'd0, '0, '0},
      '{32'd5, 32'd3, 32'd20, 8'h78, 1'b0, 2'd0, '0, '0},
      // The destination offset moves after the first source byte but before
      // the first destination byte, so its mask takes the new offset.
      '{32'd7, 32'd0, 32'd16, 8'h01, 1'b0, 2'd0, '0, '0},
      '{32'd7, 32'd5, 32'd16, 8'hAA, 1'b0, 2'd0, '0, '0},
      '{32'd7, 32'd5, 32'd16, 8'h55, 1'b0, 2'd0, '0, '0},
      '{32'd2, 32'd3, 32'd0, 8'h12, 1'b1, 2'd0, '0, '0}
    };

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      if (rows[i].src_word[2:0] != cfg_src_off || rows[i].dst_word[2:0] != cfg_dst_off ||
          rows[i].count_word[CountW-1:0] != cfg_count) begin
        write_config(rows[i].src_word, rows[i].dst_word, rows[i].count_word);
      end
      typed_on = rows[i].typed;
      typed_n = int'(rows[i].n_res);
      typed_r0 = rows[i].res0;
      typed_r1 = rows[i].res1;
      send_src_byte(rows[i].src_byte);
    end
    typed_on = 1'b0;

    drain_dest_bytes();
    apb_write(bfcr_pkg::REG_BIT_COUNT, 32'hFFFF_FFFF);
    apb_read_check(bfcr_pkg::REG_BIT_COUNT, 32'h00FF_FFFF);
    apb_write(bfcr_pkg::REG_NONE, $urandom);

    for (int ph = 0; ph < NumPhases; ph++) begin
      src_idle_pct = src_idle_tab[ph];
      sink_stall_pct = sink_stall_tab[ph];
      sent = 0;
      fresh = 1'b1;
      while (sent < int'(RandItems / NumPhases)) begin
        if (fresh || $urandom_range(1) == 0) begin
          s_off = 3'($urandom);
          d_off = 3'($urandom);
          pick = int'($urandom_range(99));
          if (pick < 10) cnt = '0;
          else if (pick < 11) cnt = CountW'($urandom_range(2048, 512));
          else if (pick < 45) cnt = CountW'($urandom_range(8, 1));
          else cnt = CountW'($urandom_range(64, 9));
          write_config(($urandom & 32'hFFFF_FFF8) | {29'b0, s_off},
                       ($urandom & 32'hFFFF_FFF8) | {29'b0, d_off},
                       ($urandom & 32'hFF00_0000) | {8'b0, cnt});
          fresh = 1'b0;
        end
        if (cfg_count == '0) begin
          repeat ($urandom_range(3, 1)) send_src_byte(8'($urandom));
        end else begin
          nbytes = (int'(cfg_count) + int'(cfg_src_off) + 7) / 8;
          repeat (nbytes) send_src_byte(8'($urandom));
          sent += nbytes;
        end
      end
    end

    drain_dest_bytes();
    repeat (10) @(negedge clk_i);
    if (errors == 0 && dest_bytes_due.size() == 0) begin
      $display("tb_bit_field_copy_realigner: PASS");
    end else begin
      $display("tb_bit_field_copy_realigner: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bfcr_pkg.sv
sv/bit_field_copy_realigner.sv
sim/tb_bit_field_copy_realigner.sv
